>>> rtl/jdg_pkg.sv
// Shared types and constants for the Julian date to Gregorian date converter.
`default_nettype none
package jdg_pkg;

	// Fixed field widths of the two channels.
	localparam int JD_FIELD_W = 46;
	localparam int YEAR_W     = 14;
	localparam int MONTH_W    = 4;
	localparam int DAY_W      = 5;
	localparam int HOUR_W     = 5;
	localparam int MIN_W      = 6;
	localparam int SEC_W      = 6;

	// Number of register stages from the input to the output register.
	localparam int N_STAGES = 12;

	// One advance enable per stage, stage 1 at the input side.
	typedef logic [N_STAGES:1] stage_vec_t;

	// Calendar part of a result item.
	typedef struct packed {
		logic signed [YEAR_W-1:0] year;
		logic [MONTH_W-1:0]       month;
		logic [DAY_W-1:0]         day;
	} date_t;

	// Time-of-day part of a result item.
	typedef struct packed {
		logic [HOUR_W-1:0] hour;
		logic [MIN_W-1:0]  minute;
		logic [SEC_W-1:0]  second;
	} tod_t;

endpackage
`default_nettype wire

>>> rtl/jdg_chan_if.sv
// Valid/ready channel interfaces for Julian date items and calendar result items.
`default_nettype none
interface jdg_in_if;
	import jdg_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [JD_FIELD_W-1:0] julian_date;

	modport source (output valid, output julian_date, input ready);
	modport sink (input valid, input julian_date, output ready);
endinterface

interface jdg_out_if;
	import jdg_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [YEAR_W-1:0] year;
	logic [MONTH_W-1:0]       month;
	logic [DAY_W-1:0]         day;
	logic [HOUR_W-1:0]        hour;
	logic [MIN_W-1:0]         minute;
	logic [SEC_W-1:0]         second;

	modport source (output valid, output year, output month, output day,
		output hour, output minute, output second, input ready);
	modport sink (input valid, input year, input month, input day,
		input hour, input minute, input second, output ready);
endinterface
`default_nettype wire

>>> rtl/jdg_cdiv.sv
// Two-stage divider of an unsigned value by a constant, by reciprocal and one correction.
`default_nettype none
module jdg_cdiv #(
	parameter int N_W     = 17,
	parameter int DIVISOR = 3600,
	parameter int Q_W     = 6,
	parameter int R_W     = 12
) (
	input  logic           clk,
	input  logic [1:0]     adv,
	input  logic [N_W-1:0] n,
	output logic [Q_W-1:0] q,
	output logic [R_W-1:0] r
);
	// The reciprocal is scaled by 2^N_W, so the first estimate is low by at most one.
	localparam longint unsigned RECIP = (64'd1 << N_W) / DIVISOR;
	localparam int M_W  = $clog2(RECIP + 1);
	localparam int D_W  = $clog2(DIVISOR + 1);
	localparam int R0_W = D_W + 1;
	localparam logic [M_W-1:0]  RECIP_C = M_W'(RECIP);
	localparam logic [D_W-1:0]  DIV_C   = D_W'(DIVISOR);
	localparam logic [R0_W-1:0] DIV_R0  = R0_W'(DIVISOR);

	logic [N_W+M_W-1:0] prod;
	logic [Q_W-1:0]     q0_s1;
	logic [N_W-1:0]     n_s1;
	logic [Q_W+D_W-1:0] qd;
	logic [N_W-1:0]     r_full;
	logic [R0_W-1:0]    r0;
	logic [Q_W-1:0]     q_s2;
	logic [R_W-1:0]     r_s2;

	// Estimate the quotient from the scaled reciprocal.
	assign prod = (N_W+M_W)'(n) * (N_W+M_W)'(RECIP_C);

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			q0_s1 <= prod[N_W +: Q_W];
			n_s1  <= n;
		end
	end

	// The remainder of the estimate lies below twice the divisor.
	assign qd     = (Q_W+D_W)'(q0_s1) * (Q_W+D_W)'(DIV_C);
	assign r_full = n_s1 - qd[N_W-1:0];
	assign r0     = r_full[R0_W-1:0];

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			if (r0 >= DIV_R0) begin
				q_s2 <= q0_s1 + Q_W'(1);
				r_s2 <= R_W'(r0 - DIV_R0);
			end else begin
				q_s2 <= q0_s1;
				r_s2 <= R_W'(r0);
			end
		end
	end

	assign q = q_s2;
	assign r = r_s2;
endmodule
`default_nettype wire

>>> rtl/jdg_date.sv
// Calendar date pipeline: century correction, year and month day-count floors.
`default_nettype none
module jdg_date #(
	parameter int FRAC_BITS   = 24,
	parameter int JD_INT_BITS = 22
) (
	input  logic                              clk,
	input  jdg_pkg::stage_vec_t               adv,
	input  logic [jdg_pkg::JD_FIELD_W-1:0]    julian_date,
	output jdg_pkg::date_t                    date
);
	import jdg_pkg::*;

	localparam int JD_W  = JD_INT_BITS + FRAC_BITS;
	localparam int USE_W = (JD_W < JD_FIELD_W) ? JD_W : JD_FIELD_W;
	localparam int T_W   = JD_W + 1;
	localparam int Z_W   = JD_INT_BITS + 1;
	localparam int NA_W  = Z_W + 3;
	localparam int B_W   = Z_W + 1;
	localparam int NC_W  = B_W + 7;
	localparam int D8_W  = B_W + 3;
	localparam int DF_W  = 9;
	localparam int NE_W  = DF_W + 14;

	// Scaled Meeus constants. The alpha numerator is moved up by 52 divisor
	// multiples so that it stays non-negative; that bias folds into B_OFS.
	localparam int ALPHA_DIV = 146097;
	localparam int ALPHA_OFS = 128179;
	localparam int B_OFS     = 1486;
	localparam int C_DIV     = 36525;
	localparam int C_SUB     = 12210;
	localparam int C_MUL     = 100;
	localparam int D_MUL     = 1461;
	localparam int E_MUL     = 10000;
	localparam int E_DIV     = 306001;
	localparam int E_LAST    = 13;
	localparam int YEAR_LO   = 4716;
	localparam int YEAR_HI   = 4715;

	localparam int QA_W = $clog2(((64'd1 << NA_W) - 1) / ALPHA_DIV + 1);
	localparam int QC_W = $clog2(((64'd1 << NC_W) - 1) / C_DIV + 1);
	localparam int QE_W = $clog2(((64'd1 << NE_W) - 1) / E_DIV + 1);

	// Day count of the whole months before month e, floor(30.6001 * e).
	function automatic logic [DF_W-1:0] mday_base(input logic [3:0] e);
		logic [DF_W-1:0] v;
		case (e)
			4'd0:    v = DF_W'(0);
			4'd1:    v = DF_W'(30);
			4'd2:    v = DF_W'(61);
			4'd3:    v = DF_W'(91);
			4'd4:    v = DF_W'(122);
			4'd5:    v = DF_W'(153);
			4'd6:    v = DF_W'(183);
			4'd7:    v = DF_W'(214);
			4'd8:    v = DF_W'(244);
			4'd9:    v = DF_W'(275);
			4'd10:   v = DF_W'(306);
			4'd11:   v = DF_W'(336);
			4'd12:   v = DF_W'(367);
			4'd13:   v = DF_W'(397);
			4'd14:   v = DF_W'(428);
			4'd15:   v = DF_W'(459);
			default: v = DF_W'(0);
		endcase
		return v;
	endfunction

	logic [T_W-1:0]    jd_ext;
	logic [T_W-1:0]    t;
	logic [NA_W-1:0]   na;
	logic [Z_W-1:0]    z_s1, z_s2, z_s3;
	logic [NA_W-1:0]   na_s1;
	logic [QA_W-1:0]   qa;
	logic [B_W-1:0]    b_s4, b_s5, b_s6, b_s7;
	logic [NC_W-1:0]   nc_s5;
	logic [QC_W-1:0]   qc;
	logic [D8_W-1:0]   d_full;
	logic [B_W-1:0]    diff_w;
	logic [DF_W-1:0]   diff_s8, diff_s9, diff_s10, diff_s11;
	logic [YEAR_W-1:0] c_s8, c_s9, c_s10, c_s11;
	logic [NE_W-1:0]   ne_s9;
	logic [QE_W-1:0]   qe;
	logic [DF_W-1:0]   day_w;
	date_t             date_s12;

	// Stage 1: add half a day and form the alpha numerator from the day number.
	assign jd_ext = T_W'(julian_date[USE_W-1:0]);
	assign t      = jd_ext + (T_W'(1) << (FRAC_BITS - 1));
	assign na     = NA_W'({t[T_W-1:FRAC_BITS], 2'b00}) + NA_W'(ALPHA_OFS);

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			z_s1  <= t[T_W-1:FRAC_BITS];
			na_s1 <= na;
		end
	end

	// Stages 2 and 3: century count.
	jdg_cdiv #(
		.N_W(NA_W), .DIVISOR(ALPHA_DIV), .Q_W(QA_W), .R_W($clog2(ALPHA_DIV))
	) u_div_alpha (
		.clk(clk), .adv(adv[3:2]), .n(na_s1), .q(qa), .r()
	);

	always_ff @(posedge clk) begin
		if (adv[2]) z_s2 <= z_s1;
		if (adv[3]) z_s3 <= z_s2;
	end

	// Stage 4: B = Z + 1 + alpha - floor(alpha / 4) + 1524.
	always_ff @(posedge clk) begin
		if (adv[4]) b_s4 <= B_W'(z_s3) + B_W'(qa) - B_W'(qa >> 2) + B_W'(B_OFS);
	end

	// Stage 5: numerator of the year count, scaled by 100.
	always_ff @(posedge clk) begin
		if (adv[5]) begin
			nc_s5 <= NC_W'(b_s4) * NC_W'(C_MUL) - NC_W'(C_SUB);
			b_s5  <= b_s4;
		end
	end

	// Stages 6 and 7: year count C.
	jdg_cdiv #(
		.N_W(NC_W), .DIVISOR(C_DIV), .Q_W(QC_W), .R_W($clog2(C_DIV))
	) u_div_c (
		.clk(clk), .adv(adv[7:6]), .n(nc_s5), .q(qc), .r()
	);

	always_ff @(posedge clk) begin
		if (adv[6]) b_s6 <= b_s5;
		if (adv[7]) b_s7 <= b_s6;
	end

	// Stage 8: days into the March-based year, B - floor(365.25 * C).
	assign d_full = D8_W'(qc) * D8_W'(D_MUL);
	assign diff_w = b_s7 - d_full[B_W+1:2];

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			diff_s8 <= diff_w[DF_W-1:0];
			c_s8    <= qc[YEAR_W-1:0];
		end
	end

	// Stage 9: numerator of the month count, scaled by 10000.
	always_ff @(posedge clk) begin
		if (adv[9]) begin
			ne_s9   <= NE_W'(diff_s8) * NE_W'(E_MUL);
			diff_s9 <= diff_s8;
			c_s9    <= c_s8;
		end
	end

	// Stages 10 and 11: month count E.
	jdg_cdiv #(
		.N_W(NE_W), .DIVISOR(E_DIV), .Q_W(QE_W), .R_W($clog2(E_DIV))
	) u_div_e (
		.clk(clk), .adv(adv[11:10]), .n(ne_s9), .q(qe), .r()
	);

	always_ff @(posedge clk) begin
		if (adv[10]) begin
			diff_s10 <= diff_s9;
			c_s10    <= c_s9;
		end
		if (adv[11]) begin
			diff_s11 <= diff_s10;
			c_s11    <= c_s10;
		end
	end

	// Stage 12: day of month, and the month and year branch.
	assign day_w = diff_s11 - mday_base(qe[3:0]);

	always_ff @(posedge clk) begin
		if (adv[12]) begin
			date_s12.day <= day_w[DAY_W-1:0];
			if (qe <= QE_W'(E_LAST)) begin
				date_s12.month <= MONTH_W'(qe - QE_W'(1));
				date_s12.year  <= $signed(c_s11 - YEAR_W'(YEAR_LO));
			end else begin
				date_s12.month <= MONTH_W'(qe - QE_W'(E_LAST));
				date_s12.year  <= $signed(c_s11 - YEAR_W'(YEAR_HI));
			end
		end
	end

	assign date = date_s12;
endmodule
`default_nettype wire

>>> rtl/jdg_tod.sv
// Time-of-day pipeline: rounded seconds of the day split into hour, minute and second.
`default_nettype none
module jdg_tod #(
	parameter int FRAC_BITS = 24
) (
	input  logic                           clk,
	input  jdg_pkg::stage_vec_t            adv,
	input  logic [jdg_pkg::JD_FIELD_W-1:0] julian_date,
	output jdg_pkg::tod_t                  tod
);
	import jdg_pkg::*;

	localparam int SD_W     = 17;
	localparam int P_W      = FRAC_BITS + SD_W;
	localparam int SECS_DAY = 86400;
	localparam int HOUR_DIV = 3600;
	localparam int MIN_DIV  = 60;
	localparam int QH_W     = $clog2(((64'd1 << SD_W) - 1) / HOUR_DIV + 1);
	localparam int RH_W     = $clog2(HOUR_DIV);
	localparam int QM_W     = $clog2(((64'd1 << RH_W) - 1) / MIN_DIV + 1);
	localparam int RM_W     = $clog2(MIN_DIV);

	logic [FRAC_BITS-1:0] f_s1;
	logic [P_W-1:0]       p_s2;
	logic [SD_W-1:0]      secs_w;
	logic [SD_W-1:0]      secs_s3;
	logic [QH_W-1:0]      qh;
	logic [RH_W-1:0]      rh;
	logic [QH_W-1:0]      hour_s6, hour_s7;
	logic [QM_W-1:0]      qm;
	logic [RM_W-1:0]      rm;
	tod_t                 tod_s [8:N_STAGES];

	// Stage 1: adding half a day to the fraction flips its top bit.
	always_ff @(posedge clk) begin
		if (adv[1]) f_s1 <= julian_date[FRAC_BITS-1:0] ^ (FRAC_BITS'(1) << (FRAC_BITS - 1));
	end

	// Stage 2: scale to seconds with round to nearest.
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			p_s2 <= P_W'(f_s1) * P_W'(SECS_DAY) + (P_W'(1) << (FRAC_BITS - 1));
		end
	end

	// Stage 3: a count that rounds up to midnight stays at the last second of the day.
	assign secs_w = p_s2[P_W-1:FRAC_BITS];

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			if (secs_w >= SD_W'(SECS_DAY)) secs_s3 <= SD_W'(SECS_DAY - 1);
			else                           secs_s3 <= secs_w;
		end
	end

	// Stages 4 and 5: hours and seconds within the hour.
	jdg_cdiv #(
		.N_W(SD_W), .DIVISOR(HOUR_DIV), .Q_W(QH_W), .R_W(RH_W)
	) u_div_hour (
		.clk(clk), .adv(adv[5:4]), .n(secs_s3), .q(qh), .r(rh)
	);

	// Stages 6 and 7: minutes and seconds within the minute.
	jdg_cdiv #(
		.N_W(RH_W), .DIVISOR(MIN_DIV), .Q_W(QM_W), .R_W(RM_W)
	) u_div_min (
		.clk(clk), .adv(adv[7:6]), .n(rh), .q(qm), .r(rm)
	);

	always_ff @(posedge clk) begin
		if (adv[6]) hour_s6 <= qh;
		if (adv[7]) hour_s7 <= hour_s6;
	end

	// Stages 8 to 12: hold the time of day level with the date pipeline.
	always_ff @(posedge clk) begin
		if (adv[8]) begin
			tod_s[8].hour   <= hour_s7[HOUR_W-1:0];
			tod_s[8].minute <= qm[MIN_W-1:0];
			tod_s[8].second <= rm;
		end
		for (int k = 9; k <= N_STAGES; k++) begin
			if (adv[k]) tod_s[k] <= tod_s[k-1];
		end
	end

	assign tod = tod_s[N_STAGES];
endmodule
`default_nettype wire

>>> rtl/julian_date_to_gregorian.sv
// Top level of the Julian date to proleptic Gregorian date and time converter.
//
//   Channel    Side   Payload
//   julian     sink   julian_date: JD_INT_BITS.FRAC_BITS unsigned fixed point
//   calendar   source year, month, day, hour, minute, second
//
// One item is taken per cycle unless every stage is full and the result is not taken.
// The path has twelve register stages, of which six sit in the three
// constant dividers of the date path (century, year and month counts).
// Reset clears only the per-stage valid bits; the data registers are not reset.
// A full stage holds while every stage after it is full and the result is not taken;
// empty stages close up, so the input stays ready while any stage is empty.
`default_nettype none
module julian_date_to_gregorian #(
	parameter int FRAC_BITS   = 24,
	parameter int JD_INT_BITS = 22
) (
	input  logic       clk,
	input  logic       arst_n,
	jdg_in_if.sink     julian,
	jdg_out_if.source  calendar
);
	import jdg_pkg::*;

	stage_vec_t v_q;
	stage_vec_t adv;
	date_t      date;
	tod_t       tod;

	// A stage advances when it or some later stage is empty, or the result is taken.
	for (genvar k = 1; k <= N_STAGES; k++) begin : g_adv
		assign adv[k] = calendar.ready || !(&v_q[N_STAGES:k]);
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (adv[1]) v_q[1] <= julian.valid;
			for (int k = 2; k <= N_STAGES; k++) begin
				if (adv[k]) v_q[k] <= v_q[k-1];
			end
		end
	end

	jdg_date #(
		.FRAC_BITS(FRAC_BITS), .JD_INT_BITS(JD_INT_BITS)
	) u_date (
		.clk(clk), .adv(adv), .julian_date(julian.julian_date), .date(date)
	);

	jdg_tod #(
		.FRAC_BITS(FRAC_BITS)
	) u_tod (
		.clk(clk), .adv(adv), .julian_date(julian.julian_date), .tod(tod)
	);

	// Channel outputs.
	assign julian.ready    = adv[1];
	assign calendar.valid  = v_q[N_STAGES];
	assign calendar.year   = date.year;
	assign calendar.month  = date.month;
	assign calendar.day    = date.day;
	assign calendar.hour   = tod.hour;
	assign calendar.minute = tod.minute;
	assign calendar.second = tod.second;

`ifndef NO_ASSERTIONS
	// With any empty stage the input must be ready.
	a_ready_on_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		!(&v_q) |-> julian.ready)
		else $error("input not ready although a stage is empty");

	// Items in flight change only by items taken in and results taken out.
	a_item_count: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> $countones(v_q) == $past($countones(v_q))
			+ ($past(julian.valid && julian.ready) ? 1 : 0)
			- ($past(calendar.valid && calendar.ready) ? 1 : 0))
		else $error("item lost or repeated in the pipeline");

	// The month branch always lands on a real month and day.
	a_month_day: assert property (@(posedge clk) disable iff (!arst_n)
		calendar.valid |-> calendar.month >= 4'd1 && calendar.month <= 4'd12
			&& calendar.day != 5'd0)
		else $error("month or day out of range");

	// Saturation keeps the time of day inside one day.
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		calendar.valid |-> calendar.hour <= 5'd23 && calendar.minute <= 6'd59
			&& calendar.second <= 6'd59)
		else $error("time of day out of range");
`endif
endmodule
`default_nettype wire
